### rtl/bqf_pkg.sv
// bqf_pkg: shared types and constants of the biquad filter
// coefficient register set, register indexes and request codes
// no dependencies

package bqf_pkg;

    // coefficient format is Q3.28, fixed at 32 bits
    localparam int COEF_WIDTH    = 32;
    localparam int NUM_COEFS     = 5;
    localparam int CFG_IDX_WIDTH = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        COEF_IN_NOW    = 3'd0,
        COEF_IN_PREV1  = 3'd1,
        COEF_IN_PREV2  = 3'd2,
        COEF_OUT_PREV1 = 3'd3,
        COEF_OUT_PREV2 = 3'd4
    } t_coef_idx;

    // request codes carried on the input channel
    typedef enum logic {
        REQ_FILTER = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req;

    // the five filter weights, feedback signs already folded in
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] in_now;
        logic signed [COEF_WIDTH-1:0] in_prev1;
        logic signed [COEF_WIDTH-1:0] in_prev2;
        logic signed [COEF_WIDTH-1:0] out_prev1;
        logic signed [COEF_WIDTH-1:0] out_prev2;
    } t_coef_set;

endpackage

### rtl/biquad_iir_filter.sv
// biquad_iir_filter: second-order direct form I filter, top level
// input register, combinational multiply-accumulate, result register
// depends on bqf_pkg and bqf_mac
//
// Usage
// - input channel (i_in_valid / o_in_ready) carries a request code and a
//   Q16.16 sample; a filter beat yields exactly one o_sample_out beat,
//   a clear beat zeroes the two input and two output history entries and
//   yields nothing
// - output channel (o_out_valid / i_out_ready) gives the saturated Q16.16
//   result; results leave in request order
// - configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   the five Q3.28 weights by index; indexes past the last are ignored;
//   write only while no filter beat is in flight
// - a taken beat passes through the input register, then the result register
// - throughput: one beat per cycle unless the receiver stalls; the five
//   multiplies, the sum and the clamp sit between the input and result registers,
//   and the output history is written back in the same cycle the result is loaded
// - when the receiver stalls the result register holds, the input register
//   keeps the next filter beat, and o_in_ready drops once both are full
// - reset clears all weights and history to zero and empties both registers

module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bqf_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  logic [bqf_pkg::COEF_WIDTH-1:0]        i_cfg_data
);

    bqf_pkg::t_coef_set r_coefs;

    logic                           r_in_valid;
    logic                           r_in_req;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;

    logic signed [SAMPLE_WIDTH-1:0] r_x1, r_x2, r_y1, r_y2;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;

    logic                           w_is_clear;
    logic                           w_advance;
    logic signed [SAMPLE_WIDTH-1:0] w_y;

    // coefficient registers, the user must write only while idle; not enforced here
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bqf_pkg::COEF_IN_NOW:    r_coefs.in_now    <= i_cfg_data;
                bqf_pkg::COEF_IN_PREV1:  r_coefs.in_prev1  <= i_cfg_data;
                bqf_pkg::COEF_IN_PREV2:  r_coefs.in_prev2  <= i_cfg_data;
                bqf_pkg::COEF_OUT_PREV1: r_coefs.out_prev1 <= i_cfg_data;
                bqf_pkg::COEF_OUT_PREV2: r_coefs.out_prev2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a clear beat needs no result slot, a filter beat needs a free one
    assign w_is_clear = (r_in_req == bqf_pkg::REQ_CLEAR);
    assign w_advance  = r_in_valid && (w_is_clear || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_req    <= i_req_type;
            r_in_sample <= i_sample_in;
        end
    end

    // multiply-accumulate on the registered beat and the history
    bqf_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_coefs (r_coefs),
        .i_x     (r_in_sample),
        .i_x1    (r_x1),
        .i_x2    (r_x2),
        .i_y1    (r_y1),
        .i_y2    (r_y2),
        .o_y     (w_y)
    );

    // history update, cleared on a clear beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (w_advance) begin
            if (w_is_clear) begin
                r_x1 <= '0;
                r_x2 <= '0;
                r_y1 <= '0;
                r_y2 <= '0;
            end else begin
                r_x1 <= r_in_sample;
                r_x2 <= r_x1;
                r_y1 <= w_y;
                r_y2 <= r_y1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && !w_is_clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && !w_is_clear) begin
            r_out_data <= w_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

### rtl/bqf_mac.sv
// bqf_mac: five-tap multiply-accumulate with rounding and saturation
// forms the exact sum, rounds half up and clamps to the sample width
// depends on bqf_pkg

module bqf_mac #(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 28
) (
    input  bqf_pkg::t_coef_set        i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y2,
    output logic signed [SAMPLE_WIDTH-1:0] o_y
);

    // each product is exact in PROD_W bits, five of them plus the half need 3 more
    localparam int PROD_W = SAMPLE_WIDTH + bqf_pkg::COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SHR_W  = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX =
        {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN =
        {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [SHR_W-1:0]  w_shr;
    logic [SHR_W-SAMPLE_WIDTH:0] w_top;
    logic                     w_fits;

    // five parallel signed multiplies
    assign w_p0 = PROD_W'(i_x)  * PROD_W'(i_coefs.in_now);
    assign w_p1 = PROD_W'(i_x1) * PROD_W'(i_coefs.in_prev1);
    assign w_p2 = PROD_W'(i_x2) * PROD_W'(i_coefs.in_prev2);
    assign w_p3 = PROD_W'(i_y1) * PROD_W'(i_coefs.out_prev1);
    assign w_p4 = PROD_W'(i_y2) * PROD_W'(i_coefs.out_prev2);

    // exact sum with the rounding half folded in
    assign w_acc = ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_p2)
                 + ACC_W'(w_p3) + ACC_W'(w_p4) + HALF;

    // drop the coefficient fraction bits
    assign w_shr = SHR_W'(w_acc >>> COEF_FRAC_BITS);

    // fits when every bit above the sample sign bit copies it
    assign w_top  = w_shr[SHR_W-1:SAMPLE_WIDTH-1];
    assign w_fits = (&w_top) | ~(|w_top);

    // clamp on overflow
    always_comb begin
        if (w_fits) begin
            o_y = w_shr[SAMPLE_WIDTH-1:0];
        end else if (w_shr[SHR_W-1]) begin
            o_y = SAT_MIN;
        end else begin
            o_y = SAT_MAX;
        end
    end

endmodule

### rtl/bqf_checker.sv
// bqf_checker: port-level assertions for the biquad filter
// bound to every instance of biquad_iir_filter
// depends on bqf_pkg

module bqf_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_req_type,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("result changed while stalled");

    // input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // a fresh result follows a taken filter beat, through the input and result registers
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && i_req_type == bqf_pkg::REQ_FILTER, 2))
        else $error("result without a matching filter beat");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind biquad_iir_filter bqf_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_req_type   (i_req_type),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);
